// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the header parser modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- rtl/pnm_hdr_pkg.sv -----
// Types and constants of the binary anymap header parser.
// Used by pnm_hdr_parse, pnm_hdr_outq and the top level; depends on nothing.
package pnm_hdr_pkg;

	localparam int MAX_HDR_BYTES = 1024;
	localparam int MIN_HDR_BYTES = 10;
	localparam int VALUE_BITS    = 24;
	localparam int IDX_W         = $clog2(MAX_HDR_BYTES + 1);

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_SHORT     = 2'd2,
		ST_BAD_VALUE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_MAGIC   = 2'd0,
		PH_TOKENS  = 2'd1,
		PH_SETTLED = 2'd2
	} phase_t;

	typedef struct packed {
		status_t               status;
		logic [VALUE_BITS-1:0] image_width;
		logic [VALUE_BITS-1:0] image_height;
		logic [VALUE_BITS-1:0] max_sample;
		logic [IDX_W-1:0]      data_offset;
		logic                  is_rgb;
		logic                  wide_samples;
	} result_t;

endpackage

// ----- rtl/binary_pnm_header_parser_top.sv -----
// Top level of the binary anymap (P5/P6) header parser.
// Depends on pnm_hdr_pkg, pnm_hdr_parse and pnm_hdr_outq.

// The block takes one header byte per cycle while in_stall is low and gives one
// result per header: status, width, height, maxval, data offset and the colour and
// sample-size flags. Each byte transfer updates the parser state; the result it
// triggers goes to the output register, or to the skid register while that stalls.
// Results pass through this two-entry buffer, so bytes keep flowing while a result
// waits; in_stall rises only while both entries hold results. last_byte rearms the
// parser for the next header, and a header that reaches 1024 bytes counts as ended.
module binary_pnm_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  header_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [23:0] image_width,
	output logic [23:0] image_height,
	output logic [23:0] max_sample,
	output logic [10:0] data_offset,
	output logic        is_rgb,
	output logic        wide_samples
);

	logic                 take;
	logic                 emit;
	logic                 full;
	pnm_hdr_pkg::result_t res;
	pnm_hdr_pkg::result_t out_data;

	assign in_stall = full;
	assign take     = in_valid && !full;

	pnm_hdr_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.header_byte (header_byte),
		.last_byte   (last_byte),
		.emit        (emit),
		.res         (res)
	);

	pnm_hdr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && emit),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign status       = out_data.status;
	assign image_width  = out_data.image_width;
	assign image_height = out_data.image_height;
	assign max_sample   = out_data.max_sample;
	assign data_offset  = out_data.data_offset;
	assign is_rgb       = out_data.is_rgb;
	assign wide_samples = out_data.wide_samples;

endmodule

// ----- rtl/pnm_hdr_parse.sv -----
// Per-byte header parser: magic check, tokenizer, decimal decode and result build.
// Depends on pnm_hdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pnm_hdr_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           header_byte,
	input  logic                 last_byte,
	output logic                 emit,
	output pnm_hdr_pkg::result_t res
);

	localparam int VB = pnm_hdr_pkg::VALUE_BITS;
	localparam int IW = pnm_hdr_pkg::IDX_W;
	localparam logic [IW-1:0] MAX_IDX = IW'(pnm_hdr_pkg::MAX_HDR_BYTES);
	localparam logic [IW-1:0] MIN_IDX = IW'(pnm_hdr_pkg::MIN_HDR_BYTES);
	localparam logic [VB+3:0] VALUE_MAX = {4'd0, {VB{1'b1}}};

	logic [IW-1:0]       idx_q, idx_n, dstart_q, dstart_n;
	pnm_hdr_pkg::phase_t phase_q, phase_n;
	logic [1:0]          tok_q, tok_n;
	logic                cmt_q, cmt_n;
	logic                started_q, started_n;
	logic                closed_q, closed_n;
	logic                neg_q, neg_n;
	logic [VB-1:0]       acc_q, acc_n;
	logic                ovf_q, ovf_n;
	logic [VB-1:0]       wid_q, wid_n;
	logic [VB-1:0]       hgt_q, hgt_n;
	logic                rgb_q, rgb_n;
	logic                pend_q, pend_n;

	always_comb begin
		logic [7:0]    c;
		logic          blank;
		logic          sep;
		logic          digit;
		logic          feed;
		logic          done;
		logic          bad;
		logic [VB+3:0] nv;
		logic [VB-1:0] v;

		c     = header_byte;
		blank = (c == pnm_hdr_pkg::CH_SPACE) || (c >= pnm_hdr_pkg::CH_TAB && c <= pnm_hdr_pkg::CH_CR);
		sep   = (c == pnm_hdr_pkg::CH_SPACE) || (c == pnm_hdr_pkg::CH_TAB) ||
			(c == pnm_hdr_pkg::CH_LF) || (c == pnm_hdr_pkg::CH_CR);
		digit = (c >= pnm_hdr_pkg::CH_ZERO) && (c <= pnm_hdr_pkg::CH_NINE);
		nv    = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {{(VB){1'b0}}, c[3:0]};
		v     = neg_q ? '0 : acc_q;
		feed  = 1'b0;
		bad   = 1'b0;

		idx_n     = (idx_q < MAX_IDX) ? idx_q + 1'b1 : idx_q;
		dstart_n  = dstart_q;
		phase_n   = phase_q;
		tok_n     = tok_q;
		cmt_n     = cmt_q;
		started_n = started_q;
		closed_n  = closed_q;
		neg_n     = neg_q;
		acc_n     = acc_q;
		ovf_n     = ovf_q;
		wid_n     = wid_q;
		hgt_n     = hgt_q;
		rgb_n     = rgb_q;
		pend_n    = pend_q;
		emit      = 1'b0;
		res       = '0;

		unique case (phase_q)
			pnm_hdr_pkg::PH_MAGIC: begin
				if (idx_q == '0) begin
					if (c != pnm_hdr_pkg::CH_P) begin
						phase_n = pnm_hdr_pkg::PH_SETTLED;
						tok_n   = 2'd0;
						pend_n  = 1'b1;
					end
				end else if (idx_q == IW'(1)) begin
					if (c == pnm_hdr_pkg::CH_5 || c == pnm_hdr_pkg::CH_6) begin
						rgb_n = (c == pnm_hdr_pkg::CH_6);
					end else begin
						phase_n = pnm_hdr_pkg::PH_SETTLED;
						tok_n   = 2'd0;
						pend_n  = 1'b1;
					end
				end else begin
					if (sep) begin
						phase_n = pnm_hdr_pkg::PH_TOKENS;
					end else begin
						phase_n = pnm_hdr_pkg::PH_SETTLED;
						tok_n   = 2'd0;
						pend_n  = 1'b1;
					end
				end
			end
			pnm_hdr_pkg::PH_TOKENS: begin
				if (cmt_q) begin
					if (c == pnm_hdr_pkg::CH_LF || c == pnm_hdr_pkg::CH_CR || last_byte) begin
						cmt_n = 1'b0;
						feed  = 1'b1;
					end
				end else if (c == pnm_hdr_pkg::CH_HASH && !last_byte) begin
					cmt_n = 1'b1;
				end else begin
					feed = 1'b1;
				end
				if (feed) begin
					if (blank) begin
						if (started_q) begin
							if (tok_q == 2'd0) begin
								wid_n = v;
							end else if (tok_q == 2'd1) begin
								hgt_n = v;
							end
							if (tok_q == 2'd2) begin
								acc_n    = v;
								dstart_n = idx_n;
								phase_n  = pnm_hdr_pkg::PH_SETTLED;
								tok_n    = 2'd3;
								pend_n   = 1'b1;
							end else begin
								tok_n     = tok_q + 2'd1;
								started_n = 1'b0;
								closed_n  = 1'b0;
								neg_n     = 1'b0;
								acc_n     = '0;
							end
						end
					end else if (!started_q && (c == pnm_hdr_pkg::CH_PLUS ||
						c == pnm_hdr_pkg::CH_MINUS)) begin
						started_n = 1'b1;
						neg_n     = (c == pnm_hdr_pkg::CH_MINUS);
					end else begin
						started_n = 1'b1;
						if (digit && !closed_q) begin
							if (nv > VALUE_MAX) begin
								acc_n = {VB{1'b1}};
								ovf_n = 1'b1;
							end else begin
								acc_n = nv[VB-1:0];
							end
						end else begin
							closed_n = 1'b1;
						end
					end
				end
			end
			pnm_hdr_pkg::PH_SETTLED: begin
			end
			default: begin
			end
		endcase

		done = last_byte || (idx_n >= MAX_IDX);

		if (phase_n == pnm_hdr_pkg::PH_SETTLED) begin
			if (pend_n && (idx_n >= MIN_IDX || done)) begin
				emit   = 1'b1;
				pend_n = 1'b0;
				if (idx_n < MIN_IDX) begin
					res.status = pnm_hdr_pkg::ST_SHORT;
				end else if (tok_n != 2'd3) begin
					res.status = pnm_hdr_pkg::ST_BAD_MAGIC;
				end else begin
					bad = ovf_n || (wid_n == '0) || (hgt_n == '0) || (acc_n == '0);
					res.status       = bad ? pnm_hdr_pkg::ST_BAD_VALUE : pnm_hdr_pkg::ST_OK;
					res.image_width  = wid_n;
					res.image_height = hgt_n;
					res.max_sample   = acc_n;
					res.data_offset  = dstart_n;
					res.is_rgb       = rgb_n;
					res.wide_samples = |acc_n[VB-1:8];
				end
			end
		end else if (done) begin
			emit       = 1'b1;
			res.status = pnm_hdr_pkg::ST_SHORT;
			phase_n    = pnm_hdr_pkg::PH_SETTLED;
			pend_n     = 1'b0;
		end

		if (last_byte) begin
			idx_n     = '0;
			dstart_n  = '0;
			phase_n   = pnm_hdr_pkg::PH_MAGIC;
			tok_n     = 2'd0;
			cmt_n     = 1'b0;
			started_n = 1'b0;
			closed_n  = 1'b0;
			neg_n     = 1'b0;
			acc_n     = '0;
			ovf_n     = 1'b0;
			wid_n     = '0;
			hgt_n     = '0;
			rgb_n     = 1'b0;
			pend_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			dstart_q  <= '0;
			phase_q   <= pnm_hdr_pkg::PH_MAGIC;
			tok_q     <= 2'd0;
			cmt_q     <= 1'b0;
			started_q <= 1'b0;
			closed_q  <= 1'b0;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			wid_q     <= '0;
			hgt_q     <= '0;
			rgb_q     <= 1'b0;
			pend_q    <= 1'b0;
		end else if (take) begin
			idx_q     <= idx_n;
			dstart_q  <= dstart_n;
			phase_q   <= phase_n;
			tok_q     <= tok_n;
			cmt_q     <= cmt_n;
			started_q <= started_n;
			closed_q  <= closed_n;
			neg_q     <= neg_n;
			acc_q     <= acc_n;
			ovf_q     <= ovf_n;
			wid_q     <= wid_n;
			hgt_q     <= hgt_n;
			rgb_q     <= rgb_n;
			pend_q    <= pend_n;
		end
	end

	`ASSERT_ALWAYS(a_pend_settled, !pend_q || (phase_q == pnm_hdr_pkg::PH_SETTLED), "pending result outside settled phase")
	`ASSERT_ALWAYS(a_tok3_settled, (tok_q != 2'd3) || (phase_q == pnm_hdr_pkg::PH_SETTLED), "third token closed while parsing")
	`ASSERT_ALWAYS(a_idx_range, idx_q <= MAX_IDX, "byte index beyond header limit")
	`ASSERT_NEXT(a_emit_clears, take && emit, !pend_q, "result still pending after transfer")

endmodule

// ----- rtl/pnm_hdr_outq.sv -----
// Two-entry result buffer: output register plus skid register.
// Depends on pnm_hdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pnm_hdr_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pnm_hdr_pkg::result_t push_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pnm_hdr_pkg::result_t out_data
);

	logic                 out_v_q;
	logic                 skid_v_q;
	pnm_hdr_pkg::result_t out_q;
	pnm_hdr_pkg::result_t skid_q;
	logic                 free;

	assign free      = !out_v_q || !out_stall;
	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (free) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`ASSERT_ALWAYS(a_skid_behind_out, !skid_v_q || out_v_q, "skid entry held with empty output register")
	`ASSERT_ALWAYS(a_no_push_full, !(push && skid_v_q), "transfer into a full buffer")

endmodule
